[sv/arpe_pkg.sv]
package arpe_pkg;

  localparam int CE = 16;
  localparam int RS = 8;
  localparam int PF = 16;

  localparam int MAXN = (CE > RS) ? ((CE > PF) ? CE : PF) : ((RS > PF) ? RS : PF);
  localparam int IW  = (MAXN > 1) ? $clog2(MAXN) : 1;
  localparam int CIW = (CE > 1) ? $clog2(CE) : 1;
  localparam int RIW = (RS > 1) ? $clog2(RS) : 1;
  localparam int PIW = (PF > 1) ? $clog2(PF) : 1;
  localparam int PCW = $clog2(PF + 1);

  localparam logic [1:0] OP_SEND = 2'd0;
  localparam logic [1:0] OP_RECV = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [2:0] K_FRAME   = 3'd0;
  localparam logic [2:0] K_REQ     = 3'd1;
  localparam logic [2:0] K_REPLY   = 3'd2;
  localparam logic [2:0] K_DELIVER = 3'd3;
  localparam logic [2:0] K_DROP    = 3'd4;

  localparam logic [1:0] REG_OWN_MAC = 2'd0;
  localparam logic [1:0] REG_OWN_IP  = 2'd1;
  localparam logic [1:0] REG_RESEND  = 2'd2;
  localparam logic [1:0] REG_LIFE    = 2'd3;

  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_ARP  = 16'h0806;

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_DISP  = 4'd1;
  localparam logic [3:0] PH_RDEC  = 4'd2;
  localparam logic [3:0] PH_CSCAN = 4'd3;
  localparam logic [3:0] PH_RSCAN = 4'd4;
  localparam logic [3:0] PH_SDEC  = 4'd5;
  localparam logic [3:0] PH_LWR   = 4'd6;
  localparam logic [3:0] PH_FLUSH = 4'd7;
  localparam logic [3:0] PH_RQCLR = 4'd8;
  localparam logic [3:0] PH_TCK   = 4'd9;
  localparam logic [3:0] PH_TEXP  = 4'd10;
  localparam logic [3:0] PH_TREQ  = 4'd11;
  localparam logic [3:0] PH_FIN   = 4'd12;

  typedef struct packed {
    logic [3:0]    phase;
    logic [IW-1:0] idx;
    logic          load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       arp_ok;
    logic       stall;
  } sts_t;

endpackage

[sv/arp_resolution_engine.sv]
// channel  dir  handshake                 payload
// s_axis   in   s_axis_tvalid/tready      tuser op, tdata item fields
// m_axis   out  m_axis_tvalid/tready      tuser kind, tdata mac/ip/handle, tlast
// cfg      in   cfg_valid_i/cfg_ready_o   cfg_addr_i register index, cfg_data_i
//
// A sequencer walks the cache, request and pending stores one entry per
// cycle while the output does not stall. Result beats leave through a
// hold stage and an output register; a stalled output freezes the
// sequencer. Reset clears valid bits, fill count, time, own MAC and own
// IP and loads the resend and lifetime defaults; no clearing pass.
module arp_resolution_engine import arpe_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [1:0]   s_axis_tuser,  // op
  // peer_ip, peer_mac, dest_mac, ether_type, arp_target_ip, arp_is_request,
  // payload_ok, frame_handle, elapsed_ms
  input  logic [215:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [2:0]   m_axis_tuser,  // kind
  output logic [95:0]  m_axis_tdata,  // out_mac, out_ip, out_handle
  output logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_addr_i,
  input  logic [47:0]  cfg_data_i
);

  cmd_t        cmd;
  sts_t        sts;
  logic        idle, in_fire;
  logic [47:0] o_mac;
  logic [31:0] o_ip;
  logic [15:0] o_hdl;

  assign s_axis_tready = idle;
  assign in_fire       = s_axis_tvalid && idle;
  assign cfg_ready_o   = 1'b1;

  arpe_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .idle_o    (idle)
  );

  arpe_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .op_i         (s_axis_tuser),
    .item_i       (s_axis_tdata[209:0]),
    .cfg_we_i     (cfg_valid_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_kind_o   (m_axis_tuser),
    .out_mac_o    (o_mac),
    .out_ip_o     (o_ip),
    .out_handle_o (o_hdl),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {o_hdl, o_ip, o_mac};

endmodule

[sv/arpe_ctrl.sv]
module arpe_ctrl import arpe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_fire_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic idle_o
);

  logic [3:0]    state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic          last_c, last_r, last_p;

  assign last_c = idx_q == IW'(CE - 1);
  assign last_r = idx_q == IW'(RS - 1);
  assign last_p = idx_q == IW'(PF - 1);

  always_comb begin
    state_d = state_q;
    idx_d   = '0;
    unique case (state_q)
      PH_IDLE:  if (in_fire_i) state_d = PH_DISP;
      PH_DISP: begin
        unique case (sts_i.op)
          OP_SEND: state_d = PH_CSCAN;
          OP_RECV: state_d = PH_RDEC;
          OP_TICK: state_d = PH_TCK;
          default: state_d = PH_FIN;
        endcase
      end
      PH_RDEC:  state_d = sts_i.arp_ok ? PH_CSCAN : PH_FIN;
      PH_CSCAN: begin
        if (last_c) state_d = (sts_i.op == OP_SEND) ? PH_RSCAN : PH_LWR;
        else idx_d = idx_q + 1'b1;
      end
      PH_RSCAN: begin
        if (last_r) state_d = PH_SDEC;
        else idx_d = idx_q + 1'b1;
      end
      PH_SDEC:  state_d = PH_FIN;
      PH_LWR:   state_d = PH_FLUSH;
      PH_FLUSH: begin
        if (last_p) state_d = PH_RQCLR;
        else idx_d = idx_q + 1'b1;
      end
      PH_RQCLR: begin
        if (last_r) state_d = PH_FIN;
        else idx_d = idx_q + 1'b1;
      end
      PH_TCK:   state_d = PH_TEXP;
      PH_TEXP: begin
        if (last_c) state_d = PH_TREQ;
        else idx_d = idx_q + 1'b1;
      end
      PH_TREQ: begin
        if (last_r) state_d = PH_FIN;
        else idx_d = idx_q + 1'b1;
      end
      PH_FIN:   state_d = PH_IDLE;
      default:  state_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PH_IDLE;
      idx_q   <= '0;
    end else if (!sts_i.stall) begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign idle_o      = state_q == PH_IDLE;
  assign cmd_o.phase = state_q;
  assign cmd_o.idx   = idx_q;
  assign cmd_o.load  = in_fire_i;

endmodule

[sv/arpe_dp.sv]
module arpe_dp import arpe_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cmd_t         cmd_i,
  output sts_t         sts_o,
  input  logic [1:0]   op_i,
  input  logic [209:0] item_i,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_addr_i,
  input  logic [47:0]  cfg_data_i,
  input  logic         out_ready_i,
  output logic         out_valid_o,
  output logic [2:0]   out_kind_o,
  output logic [47:0]  out_mac_o,
  output logic [31:0]  out_ip_o,
  output logic [15:0]  out_handle_o,
  output logic         out_last_o
);

  logic [47:0] own_mac_q;
  logic [31:0] own_ip_q, resend_q, life_q;
  logic [47:0] now_q;

  logic [1:0]  op_q;
  logic [31:0] ip_q, tip_q;
  logic [47:0] smac_q, dmac_q;
  logic [15:0] et_q, hdl_q, elap_q;
  logic        isreq_q, pok_q;

  logic        cvalid_q [CE];
  logic [31:0] cip_q    [CE];
  logic [47:0] cmac_q   [CE];
  logic [47:0] cstamp_q [CE];
  logic        rvalid_q [RS];
  logic [31:0] rip_q    [RS];
  logic [47:0] rstamp_q [RS];
  logic [31:0] pip_q    [PF];
  logic [15:0] phdl_q   [PF];
  logic [PCW-1:0] pcnt_q, k_q;

  logic           hit_q, cfree_q, rfound_q, rfree_q;
  logic [47:0]    hmac_q, old_stamp_q, rfstamp_q;
  logic [CIW-1:0] cm_q, cf_q, old_q;
  logic [RIW-1:0] ridx_q, fidx_q;

  logic        hold_v_q, out_v_q;
  logic [2:0]  hkind_q;
  logic [47:0] hmac_o_q;
  logic [31:0] hip_q;
  logic [15:0] hhdl_q;

  logic           act, stall, fin, push;
  logic           em_v;
  logic [2:0]     em_kind;
  logic [47:0]    em_mac;
  logic [31:0]    em_ip;
  logic [15:0]    em_hdl;
  logic [CIW-1:0] ci;
  logic [RIW-1:0] ri;
  logic [PIW-1:0] pi;
  logic           in_pend, drop, rstale, treq_stale, flush_hit;
  logic [48:0]    tick_sum;
  logic [CIW-1:0] lslot;

  assign ci = cmd_i.idx[CIW-1:0];
  assign ri = cmd_i.idx[RIW-1:0];
  assign pi = cmd_i.idx[PIW-1:0];

  assign stall = hold_v_q && out_v_q && !out_ready_i;
  assign act   = !stall;
  assign fin   = cmd_i.phase == PH_FIN;
  assign push  = act && hold_v_q && (em_v || fin);

  assign in_pend    = 32'(cmd_i.idx) < 32'(pcnt_q);
  assign flush_hit  = in_pend && (pip_q[pi] == ip_q);
  assign drop       = (32'(pcnt_q) >= 32'(PF)) || (!rfound_q && !rfree_q);
  assign rstale     = ({1'b0, rfstamp_q} + {17'b0, resend_q}) < {1'b0, now_q};
  assign treq_stale = rvalid_q[ri] &&
                      (({1'b0, rstamp_q[ri]} + {17'b0, resend_q}) < {1'b0, now_q});
  assign tick_sum   = {1'b0, now_q} + {33'b0, elap_q};
  assign lslot      = hit_q ? cm_q : (cfree_q ? cf_q : old_q);

  always_comb begin
    em_v    = 1'b0;
    em_kind = K_FRAME;
    em_mac  = '0;
    em_ip   = '0;
    em_hdl  = '0;
    case (cmd_i.phase)
      PH_RDEC: begin
        em_v    = pok_q && (et_q == ETH_IPV4) && (dmac_q == own_mac_q);
        em_kind = K_DELIVER;
        em_hdl  = hdl_q;
      end
      PH_SDEC: begin
        em_ip = ip_q;
        if (hit_q) begin
          em_v    = 1'b1;
          em_kind = K_FRAME;
          em_mac  = hmac_q;
          em_hdl  = hdl_q;
        end else if (drop) begin
          em_v    = 1'b1;
          em_kind = K_DROP;
          em_hdl  = hdl_q;
        end else begin
          em_v    = !rfound_q || rstale;
          em_kind = K_REQ;
          em_mac  = '1;
        end
      end
      PH_LWR: begin
        em_v    = (tip_q == own_ip_q) && isreq_q;
        em_kind = K_REPLY;
        em_mac  = smac_q;
        em_ip   = ip_q;
      end
      PH_FLUSH: begin
        em_v    = flush_hit;
        em_kind = K_FRAME;
        em_mac  = smac_q;
        em_ip   = ip_q;
        em_hdl  = phdl_q[pi];
      end
      PH_TREQ: begin
        em_v    = treq_stale;
        em_kind = K_REQ;
        em_mac  = '1;
        em_ip   = rip_q[ri];
      end
      default: em_v = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q <= '0;
      own_ip_q  <= '0;
      resend_q  <= 32'd5000;
      life_q    <= 32'd30000;
      now_q     <= '0;
      pcnt_q    <= '0;
      hold_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
      for (int j = 0; j < CE; j++) cvalid_q[j] <= 1'b0;
      for (int j = 0; j < RS; j++) rvalid_q[j] <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          REG_OWN_MAC: own_mac_q <= cfg_data_i;
          REG_OWN_IP:  own_ip_q  <= cfg_data_i[31:0];
          REG_RESEND:  resend_q  <= cfg_data_i[31:0];
          REG_LIFE:    life_q    <= cfg_data_i[31:0];
          default:     own_mac_q <= own_mac_q;
        endcase
      end
      if (out_ready_i) out_v_q <= 1'b0;
      if (push) out_v_q <= 1'b1;
      if (act) begin
        if (em_v) hold_v_q <= 1'b1;
        else if (fin) hold_v_q <= 1'b0;
        case (cmd_i.phase)
          PH_SDEC: begin
            if (!hit_q && !drop) begin
              if (!rfound_q) rvalid_q[fidx_q] <= 1'b1;
              pcnt_q <= pcnt_q + 1'b1;
            end
          end
          PH_LWR: cvalid_q[lslot] <= 1'b1;
          PH_FLUSH: begin
            if (cmd_i.idx == IW'(PF - 1))
              pcnt_q <= (in_pend && !flush_hit) ? k_q + 1'b1 : k_q;
          end
          PH_RQCLR: if (rvalid_q[ri] && rip_q[ri] == ip_q) rvalid_q[ri] <= 1'b0;
          PH_TCK:   now_q <= tick_sum[48] ? '1 : tick_sum[47:0];
          PH_TEXP: begin
            if (cvalid_q[ci] &&
                (({1'b0, cstamp_q[ci]} + {17'b0, life_q}) < {1'b0, now_q}))
              cvalid_q[ci] <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_kind_o   <= hkind_q;
      out_mac_o    <= hmac_o_q;
      out_ip_o     <= hip_q;
      out_handle_o <= hhdl_q;
      out_last_o   <= fin;
    end
    if (act && em_v) begin
      hkind_q  <= em_kind;
      hmac_o_q <= em_mac;
      hip_q    <= em_ip;
      hhdl_q   <= em_hdl;
    end
    if (cmd_i.load) begin
      op_q     <= op_i;
      ip_q     <= item_i[31:0];
      smac_q   <= item_i[79:32];
      dmac_q   <= item_i[127:80];
      et_q     <= item_i[143:128];
      tip_q    <= item_i[175:144];
      isreq_q  <= item_i[176];
      pok_q    <= item_i[177];
      hdl_q    <= item_i[193:178];
      elap_q   <= item_i[209:194];
      hit_q    <= 1'b0;
      cfree_q  <= 1'b0;
      rfound_q <= 1'b0;
      rfree_q  <= 1'b0;
      k_q      <= '0;
    end
    if (act) begin
      case (cmd_i.phase)
        PH_CSCAN: begin
          if (cvalid_q[ci] && cip_q[ci] == ip_q && !hit_q) begin
            hit_q  <= 1'b1;
            cm_q   <= ci;
            hmac_q <= cmac_q[ci];
          end
          if (!cvalid_q[ci] && !cfree_q) begin
            cfree_q <= 1'b1;
            cf_q    <= ci;
          end
          if (cmd_i.idx == '0 || cstamp_q[ci] < old_stamp_q) begin
            old_q       <= ci;
            old_stamp_q <= cstamp_q[ci];
          end
        end
        PH_RSCAN: begin
          if (rvalid_q[ri] && rip_q[ri] == ip_q && !rfound_q) begin
            rfound_q  <= 1'b1;
            ridx_q    <= ri;
            rfstamp_q <= rstamp_q[ri];
          end
          if (!rvalid_q[ri] && !rfree_q) begin
            rfree_q <= 1'b1;
            fidx_q  <= ri;
          end
        end
        PH_SDEC: begin
          if (!hit_q && !drop) begin
            if (!rfound_q) begin
              rip_q[fidx_q]    <= ip_q;
              rstamp_q[fidx_q] <= now_q;
            end else if (rstale) begin
              rstamp_q[ridx_q] <= now_q;
            end
            pip_q[pcnt_q[PIW-1:0]]  <= ip_q;
            phdl_q[pcnt_q[PIW-1:0]] <= hdl_q;
          end
        end
        PH_LWR: begin
          cip_q[lslot]    <= ip_q;
          cmac_q[lslot]   <= smac_q;
          cstamp_q[lslot] <= now_q;
        end
        PH_FLUSH: begin
          if (in_pend && !flush_hit) begin
            pip_q[k_q[PIW-1:0]]  <= pip_q[pi];
            phdl_q[k_q[PIW-1:0]] <= phdl_q[pi];
            k_q <= k_q + 1'b1;
          end
        end
        PH_TREQ: if (treq_stale) rstamp_q[ri] <= now_q;
        default: ;
      endcase
    end
  end

  assign out_valid_o  = out_v_q;
  assign sts_o.op     = op_q;
  assign sts_o.arp_ok = pok_q && (et_q == ETH_ARP);
  assign sts_o.stall  = stall;

endmodule

[test/testbench.sv]
module testbench import arpe_pkg::*; ();

  typedef struct {
    logic [1:0]  op;
    logic [31:0] peer_ip;
    logic [47:0] peer_mac;
    logic [47:0] dest_mac;
    logic [15:0] ether_type;
    logic [31:0] tgt_ip;
    logic        is_req;
    logic        pay_ok;
    logic [15:0] handle;
    logic [15:0] elapsed;
  } arp_item_t;

  typedef struct {
    logic [2:0]  kind;
    logic [47:0] mac;
    logic [31:0] ip;
    logic [15:0] handle;
    logic        last;
  } arp_res_t;

  localparam logic [63:0] TIME_MAX = 64'hFFFF_FFFF_FFFF;
  localparam int IDLE_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [1:0] s_axis_tuser = '0;
  logic [215:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [2:0] m_axis_tuser;
  logic [95:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_addr_i = '0;
  logic [47:0] cfg_data_i = '0;

  arp_resolution_engine dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [47:0] p_own_mac;
  logic [31:0] p_own_ip;
  logic [63:0] p_resend, p_life, p_now;
  logic        c_vld[CE];
  logic [31:0] c_ip[CE];
  logic [47:0] c_mac[CE];
  logic [63:0] c_stamp[CE];
  logic        r_vld[RS];
  logic [31:0] r_ip[RS];
  logic [63:0] r_stamp[RS];
  logic        q_vld[PF];
  logic [31:0] q_ip[PF];
  logic [15:0] q_hnd[PF];

  arp_item_t pending_items[$];
  arp_res_t  step_res[$];
  arp_res_t  awaited_res[$];
  int        errors = 0;
  int        hold_req = 0;
  bit        no_gaps = 0;
  logic [31:0] ip_pool[20];

  function automatic void add_res(logic [2:0] k, logic [47:0] m, logic [31:0] ip,
                                  logic [15:0] h);
    arp_res_t r;
    r.kind = k; r.mac = m; r.ip = ip; r.handle = h; r.last = 1'b0;
    step_res.insert(step_res.size(), r);
  endfunction

  function automatic void learn_mapping(logic [31:0] ip, logic [47:0] mac);
    int slot;
    slot = -1;
    for (int i = 0; i < CE && slot < 0; i++) if (c_vld[i] && c_ip[i] == ip) slot = i;
    for (int i = 0; i < CE && slot < 0; i++) if (!c_vld[i]) slot = i;
    if (slot < 0) begin
      slot = 0;
      for (int i = 1; i < CE; i++) if (c_stamp[i] < c_stamp[slot]) slot = i;
    end
    c_vld[slot] = 1'b1; c_ip[slot] = ip; c_mac[slot] = mac; c_stamp[slot] = p_now;
  endfunction

  function automatic void resolve_send(logic [31:0] ip, logic [15:0] h);
    int hit, cnt, r, fr;
    hit = -1; cnt = 0; r = -1; fr = -1;
    for (int i = CE - 1; i >= 0; i--) if (c_vld[i] && c_ip[i] == ip) hit = i;
    if (hit >= 0) begin
      add_res(K_FRAME, c_mac[hit], ip, h);
      return;
    end
    for (int i = 0; i < PF; i++) if (q_vld[i]) cnt++;
    for (int i = RS - 1; i >= 0; i--) begin
      if (r_vld[i] && r_ip[i] == ip) r = i;
      if (!r_vld[i]) fr = i;
    end
    if (cnt >= PF || (r < 0 && fr < 0)) begin
      add_res(K_DROP, '0, ip, h);
      return;
    end
    if (r < 0) begin
      r_vld[fr] = 1'b1; r_ip[fr] = ip; r_stamp[fr] = p_now;
      add_res(K_REQ, '1, ip, '0);
    end else if (r_stamp[r] + p_resend < p_now) begin
      r_stamp[r] = p_now;
      add_res(K_REQ, '1, ip, '0);
    end
    q_vld[cnt] = 1'b1; q_ip[cnt] = ip; q_hnd[cnt] = h;
  endfunction

  function automatic void resolve_recv(arp_item_t it);
    int k;
    k = 0;
    if (!it.pay_ok) return;
    if (it.ether_type == ETH_IPV4) begin
      if (it.dest_mac == p_own_mac) add_res(K_DELIVER, '0, '0, it.handle);
      return;
    end
    if (it.ether_type != ETH_ARP) return;
    learn_mapping(it.peer_ip, it.peer_mac);
    if (it.tgt_ip == p_own_ip && it.is_req) add_res(K_REPLY, it.peer_mac, it.peer_ip, '0);
    for (int i = 0; i < PF; i++) begin
      if (q_vld[i]) begin
        if (q_ip[i] == it.peer_ip) add_res(K_FRAME, it.peer_mac, it.peer_ip, q_hnd[i]);
        else begin
          q_ip[k] = q_ip[i]; q_hnd[k] = q_hnd[i]; k++;
        end
      end
    end
    for (int i = 0; i < PF; i++) q_vld[i] = (i < k);
    for (int i = 0; i < RS; i++)
      if (r_vld[i] && r_ip[i] == it.peer_ip) begin
        r_vld[i] = 1'b0;
        break;
      end
  endfunction

  function automatic void advance_time(logic [15:0] el);
    p_now = p_now + {48'b0, el};
    if (p_now > TIME_MAX) p_now = TIME_MAX;
    for (int i = 0; i < CE; i++)
      if (c_vld[i] && c_stamp[i] + p_life < p_now) c_vld[i] = 1'b0;
    for (int i = 0; i < RS; i++)
      if (r_vld[i] && r_stamp[i] + p_resend < p_now) begin
        r_stamp[i] = p_now;
        add_res(K_REQ, '1, r_ip[i], '0);
      end
  endfunction

  function automatic void predict_item(arp_item_t it);
    step_res.delete();
    case (it.op)
      OP_SEND: resolve_send(it.peer_ip, it.handle);
      OP_RECV: resolve_recv(it);
      OP_TICK: advance_time(it.elapsed);
      default: ;
    endcase
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) awaited_res.insert(awaited_res.size(), step_res[i]);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk_i) begin
    logic nv;
    arp_item_t it;
    nv = s_axis_tvalid;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_item(pending_items.pop_front());
        nv = 1'b0;
        in_gap = pick_gap();
      end
      if (!nv) begin
        if (in_gap > 0) in_gap--;
        else if (pending_items.size() > 0) begin
          it = pending_items[0];
          nv = 1'b1;
          s_axis_tuser <= it.op;
          s_axis_tdata <= {6'b0, it.elapsed, it.handle, it.pay_ok, it.is_req, it.tgt_ip,
                           it.ether_type, it.dest_mac, it.peer_mac, it.peer_ip};
        end
      end
    end
    s_axis_tvalid <= nv;
  end

  // monitor
  int out_hold = 0;
  always @(posedge clk_i) begin
    arp_res_t e;
    int r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_res.size() == 0) begin
        $error("unexpected beat kind=%0d tdata=%h", m_axis_tuser, m_axis_tdata);
        errors++;
      end else begin
        e = awaited_res.pop_front();
        if (m_axis_tuser !== e.kind) begin
          $error("kind exp %0d got %0d", e.kind, m_axis_tuser); errors++;
        end
        if (m_axis_tdata[47:0] !== e.mac) begin
          $error("out_mac exp %h got %h", e.mac, m_axis_tdata[47:0]); errors++;
        end
        if (m_axis_tdata[79:48] !== e.ip) begin
          $error("out_ip exp %h got %h", e.ip, m_axis_tdata[79:48]); errors++;
        end
        if (m_axis_tdata[95:80] !== e.handle) begin
          $error("out_handle exp %h got %h", e.handle, m_axis_tdata[95:80]); errors++;
        end
        if (m_axis_tlast !== e.last) begin
          $error("last exp %0d got %0d", e.last, m_axis_tlast); errors++;
        end
      end
    end
    if (hold_req > 0) begin
      out_hold = hold_req;
      hold_req = 0;
    end
    if (out_hold > 0) begin
      out_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (no_gaps || r < 70) m_axis_tready <= 1'b1;
      else if (r < 97) m_axis_tready <= 1'b0;
      else begin
        out_hold = $urandom_range(10, 40);
        m_axis_tready <= 1'b0;
      end
    end
  end

  // watchdog
  int quiet = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) quiet = 0;
    else quiet++;
    if (quiet >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_OWN_MAC: p_own_mac = val;
      REG_OWN_IP:  p_own_ip = val[31:0];
      REG_RESEND:  p_resend = {32'b0, val[31:0]};
      default:     p_life = {32'b0, val[31:0]};
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || s_axis_tvalid || awaited_res.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic arp_item_t noise_item();
    arp_item_t it;
    it.op = 2'($urandom_range(0, 3));
    it.peer_ip = $urandom; it.peer_mac = 48'({$urandom, $urandom});
    it.dest_mac = 48'({$urandom, $urandom}); it.ether_type = 16'($urandom);
    it.tgt_ip = $urandom; it.is_req = 1'($urandom); it.pay_ok = 1'($urandom);
    it.handle = 16'($urandom); it.elapsed = 16'($urandom);
    return it;
  endfunction

  function automatic arp_item_t send_item(logic [31:0] ip);
    arp_item_t it;
    it = noise_item();
    it.op = OP_SEND; it.peer_ip = ip;
    return it;
  endfunction

  function automatic arp_item_t arp_item(logic [31:0] ip, logic [47:0] mac, logic rq,
                                         logic [31:0] tgt);
    arp_item_t it;
    it = noise_item();
    it.op = OP_RECV; it.peer_ip = ip; it.peer_mac = mac; it.is_req = rq;
    it.tgt_ip = tgt; it.ether_type = ETH_ARP; it.pay_ok = 1'b1;
    return it;
  endfunction

  function automatic arp_item_t tick_item(logic [15:0] el);
    arp_item_t it;
    it = noise_item();
    it.op = OP_TICK; it.elapsed = el;
    return it;
  endfunction

  function automatic arp_item_t random_item();
    arp_item_t it;
    int r;
    logic [31:0] ip;
    r = $urandom_range(0, 99);
    ip = ip_pool[$urandom_range(0, 19)];
    if (r < 38) it = send_item(ip);
    else if (r < 60) begin
      it = arp_item(ip, 48'({$urandom, $urandom}), 1'($urandom),
                    ($urandom_range(0, 1) != 0) ? p_own_ip : $urandom);
      if ($urandom_range(0, 15) == 0) it.pay_ok = 1'b0;
    end else if (r < 70) begin
      it = noise_item();
      it.op = OP_RECV; it.ether_type = ETH_IPV4; it.pay_ok = $urandom_range(0, 7) != 0;
      if ($urandom_range(0, 1) != 0) it.dest_mac = p_own_mac;
    end else if (r < 88) begin
      it = tick_item(($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 800)));
    end else it = noise_item();
    return it;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) pending_items.insert(pending_items.size(), random_item());
  endtask

  initial begin
    arp_item_t it;
    p_own_mac = '0; p_own_ip = '0; p_resend = 64'd5000; p_life = 64'd30000; p_now = '0;
    for (int i = 0; i < CE; i++) c_vld[i] = 1'b0;
    for (int i = 0; i < RS; i++) r_vld[i] = 1'b0;
    for (int i = 0; i < PF; i++) q_vld[i] = 1'b0;
    for (int i = 0; i < 20; i++) ip_pool[i] = $urandom;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    write_reg(REG_OWN_MAC, 48'({$urandom, $urandom}));
    write_reg(REG_OWN_IP, {16'b0, $urandom});
    pending_items.insert(pending_items.size(), send_item(ip_pool[0]));
    pending_items.insert(pending_items.size(), send_item(ip_pool[0]));
    pending_items.insert(pending_items.size(), tick_item(16'hFFFF));
    pending_items.insert(pending_items.size(), send_item(ip_pool[0]));
    pending_items.insert(pending_items.size(), arp_item(ip_pool[0], '1, 1'b1, p_own_ip));
    pending_items.insert(pending_items.size(), send_item(ip_pool[0]));
    it = arp_item(32'h0, '0, 1'b0, '0); it.ether_type = ETH_IPV4; it.dest_mac = p_own_mac;
    pending_items.insert(pending_items.size(), it);
    it.dest_mac = ~p_own_mac;
    pending_items.insert(pending_items.size(), it);
    it = arp_item(ip_pool[1], '0, 1'b1, p_own_ip); it.pay_ok = 1'b0;
    pending_items.insert(pending_items.size(), it);
    it.pay_ok = 1'b1; it.ether_type = 16'hFFFF;
    pending_items.insert(pending_items.size(), it);
    it = noise_item(); it.op = 2'd3;
    pending_items.insert(pending_items.size(), it);
    pending_items.insert(pending_items.size(), tick_item(16'h0));
    for (int i = 1; i <= 9; i++)
      pending_items.insert(pending_items.size(), send_item(ip_pool[i]));
    for (int i = 0; i < 8; i++)
      pending_items.insert(pending_items.size(), send_item(ip_pool[1]));
    pending_items.insert(pending_items.size(),
                         arp_item(ip_pool[1], 48'({$urandom, $urandom}), 1'b0, '0));
    wait_idle();

    // extremes: no resend hold-off, immediate expiry
    write_reg(REG_RESEND, 48'h0);
    write_reg(REG_LIFE, 48'h0);
    random_phase(70);
    wait_idle();

    // fast timers, receiver held off long
    write_reg(REG_OWN_MAC, '1);
    write_reg(REG_OWN_IP, {16'b0, ip_pool[3]});
    write_reg(REG_RESEND, 48'd300);
    write_reg(REG_LIFE, 48'd2000);
    random_phase(80);
    hold_req = 400;
    wait_idle();

    // no idling at all
    no_gaps = 1;
    write_reg(REG_OWN_MAC, '0);
    write_reg(REG_OWN_IP, '0);
    random_phase(50);
    wait_idle();
    no_gaps = 0;

    // timers at maximum
    write_reg(REG_OWN_MAC, 48'({$urandom, $urandom}));
    write_reg(REG_RESEND, 48'hFFFF_FFFF);
    write_reg(REG_LIFE, 48'hFFFF_FFFF);
    random_phase(90);
    wait_idle();

    repeat (100) @(posedge clk_i);
    if (errors == 0 && awaited_res.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[arp_resolution_engine.f]
sv/arpe_pkg.sv
sv/arpe_ctrl.sv
sv/arpe_dp.sv
sv/arp_resolution_engine.sv
test/testbench.sv
